/* rtl/stereo_multitap_chorus_defines.svh */
// ---------------------------------------------------------------------------
// Stereo multitap chorus assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled while
// rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef STEREO_MULTITAP_CHORUS_DEFINES_SVH
`define STEREO_MULTITAP_CHORUS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/smc_pkg.sv */
// ---------------------------------------------------------------------------
// Stereo multitap chorus package
// Payload types, register map, lane control bundle and the reciprocal
// table that turns the division by the voice count into a multiplication.
// ---------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int VC_W     = 4;
  localparam int TAP_W    = 12;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_VOICE_COUNT = 3'h0;
  localparam logic [ADDR_W-1:0] REG_TAP_SPACING = 3'h4;

  localparam logic [VC_W-1:0]  VC_RESET = 4'd4;
  localparam logic [TAP_W-1:0] TS_RESET = 12'd440;

  // Reciprocal division: floor(m / d) = (m * ceil(2^24 / d)) >> 24 holds
  // exactly for any magnitude m below 2^20 and any divisor d up to 16.
  localparam int MAG_W       = 20;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int Q_W         = SAMPLE_W + 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // Sequencer to lane control bundle.
  typedef struct packed {
    logic wr_en;     // store the current sample
    logic rd_en;     // read one delayed tap
    logic acc_load;  // start the sum with the current sample
    logic acc_add;   // add the tap that arrived from the store
    logic mul_en;    // take the magnitude times the reciprocal
  } lane_ctrl_t;

  // ceil(2^24 / d), indexed by d - 1.
  function automatic logic [RECIP_W-1:0] recip(input logic [VC_W-1:0] dm1);
    logic [RECIP_W-1:0] r;
    case (dm1)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd8388608;
      4'd2:    r = 25'd5592406;
      4'd3:    r = 25'd4194304;
      4'd4:    r = 25'd3355444;
      4'd5:    r = 25'd2796203;
      4'd6:    r = 25'd2396746;
      4'd7:    r = 25'd2097152;
      4'd8:    r = 25'd1864136;
      4'd9:    r = 25'd1677722;
      4'd10:   r = 25'd1525202;
      4'd11:   r = 25'd1398102;
      4'd12:   r = 25'd1290556;
      4'd13:   r = 25'd1198373;
      4'd14:   r = 25'd1118482;
      default: r = 25'd1048576;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/smc_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module smc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/smc_lane.sv */
// ---------------------------------------------------------------------------
// Stereo multitap chorus channel lane
// Holds one channel's delay store, sums the current sample with the taps
// read from it and forms the quotient magnitude by reciprocal multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module smc_lane #(
  parameter int DELAY_DEPTH = 4096,
  parameter int MAX_VOICES  = 8
) (
  input  wire logic                                clk_i,
  input  wire smc_pkg::lane_ctrl_t                 ctrl_i,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0]      wr_addr_i,
  input  wire logic signed [smc_pkg::SAMPLE_W-1:0] wr_data_i,
  input  wire logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr_i,
  input  wire logic [smc_pkg::RECIP_W-1:0]         recip_i,
  output      logic [smc_pkg::Q_W-1:0]             quot_o,
  output      logic                                neg_o
);

  localparam int ACC_W = smc_pkg::SAMPLE_W + $clog2(MAX_VOICES);

  logic [smc_pkg::SAMPLE_W-1:0]   rd_data;
  logic signed [ACC_W-1:0]        acc_q, acc_d;
  logic [ACC_W-1:0]               mag;
  logic [smc_pkg::PROD_W-1:0]     prod_q;
  logic                           neg_q;

  smc_ram #(
    .WIDTH (smc_pkg::SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // Running sum of the current sample and the delayed taps.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_load) begin
      acc_d = ACC_W'(wr_data_i);
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + ACC_W'($signed(rd_data));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Magnitude of the sum; the most negative sum reads correctly as unsigned.
  assign mag = acc_q[ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);

  // Magnitude times the reciprocal of the voice count.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= smc_pkg::PROD_W'(smc_pkg::MAG_W'(mag)) * smc_pkg::PROD_W'(recip_i);
      neg_q  <= acc_q[ACC_W-1];
    end
  end

  assign quot_o = prod_q[smc_pkg::RECIP_SHIFT +: smc_pkg::Q_W];
  assign neg_o  = neg_q;

endmodule

`default_nettype wire

/* rtl/stereo_multitap_chorus.sv */
// ---------------------------------------------------------------------------
// Stereo multitap chorus
// Writes each stereo sample into per-channel delay stores and averages it
// with up to MAX_VOICES-1 delayed taps, one lane per channel.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o   in_data_i  (left_in, right_in)
//   out      output     out_valid_o/out_stall_i out_data_o (left_out, right_out)
//   cfg      input      psel/penable/pready     paddr, pwdata, prdata
//
// Between acceptance and the next acceptance an item takes one store read per
// tap (nv - 1 taps, nv being the clamped voice count) on the single read port
// of each lane, then a sum, a multiply and an output stage. Both lanes run in
// lockstep.
// No clearing pass after reset: a fill mark on the write position makes
// never-written store entries read as zero.
// After reset or a tap_spacing write with a store shallower than 4096, input
// stalls while the spacing is reduced below the store depth.
// A result waiting under out_stall_i does not block the next input transaction.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stereo_multitap_chorus_defines.svh"

module stereo_multitap_chorus #(
  parameter int DELAY_DEPTH = 4096,
  parameter int MAX_VOICES  = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input channel.
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire smc_pkg::in_item_t            in_data_i,
  // Output channel.
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      smc_pkg::out_item_t           out_data_o,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [smc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [smc_pkg::DATA_W-1:0]   pwdata,
  output      logic [smc_pkg::DATA_W-1:0]   prdata,
  output      logic                         pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int XW = ((AW > smc_pkg::TAP_W) ? AW : smc_pkg::TAP_W) + 2;
  localparam logic [4:0] MaxV = 5'(MAX_VOICES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [smc_pkg::VC_W-1:0]         vc_q;
  logic [smc_pkg::TAP_W-1:0]        ts_q, ts_red_q, ts_red_d;
  logic [AW-1:0]                    pos_q, pos_d;
  logic                             wrapped_q, wrapped_d;
  logic [AW-1:0]                    idx_q, idx_d;
  logic [smc_pkg::VC_W-1:0]         taps_left_q, taps_left_d;
  logic [smc_pkg::VC_W-1:0]         nv_q, nv_d, nv_sel;
  logic                             rd_pend_q, rd_ok_q, rd_ok_d;
  logic                             out_valid_q, out_valid_d;
  smc_pkg::out_item_t               out_data_q, out_data_d;
  logic                             cfg_we, ts_big, in_acc, out_load;
  smc_pkg::lane_ctrl_t              ctrl;
  logic [smc_pkg::RECIP_W-1:0]      recip;
  logic [smc_pkg::Q_W-1:0]          quot_l, quot_r, res_l, res_r;
  logic                             neg_l, neg_r;

  // Position a tap spacing back from a, wrapping around the store.
  function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] a,
                                              input logic [smc_pkg::TAP_W-1:0] d);
    logic [XW-1:0] t;
    t = XW'(a) + XW'(DELAY_DEPTH) - XW'(d);
    if (t >= XW'(DELAY_DEPTH)) begin
      t = t - XW'(DELAY_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign ts_big = XW'(ts_red_q) >= XW'(DELAY_DEPTH);

  always_comb begin
    ts_red_d = ts_red_q;
    if (cfg_we && (paddr == smc_pkg::REG_TAP_SPACING)) begin
      ts_red_d = pwdata[smc_pkg::TAP_W-1:0];
    end else if (ts_big) begin
      ts_red_d = smc_pkg::TAP_W'(XW'(ts_red_q) - XW'(DELAY_DEPTH));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q     <= smc_pkg::VC_RESET;
      ts_q     <= smc_pkg::TS_RESET;
      ts_red_q <= smc_pkg::TS_RESET;
    end else begin
      ts_red_q <= ts_red_d;
      if (cfg_we && (paddr == smc_pkg::REG_VOICE_COUNT)) begin
        vc_q <= pwdata[smc_pkg::VC_W-1:0];
      end
      if (cfg_we && (paddr == smc_pkg::REG_TAP_SPACING)) begin
        ts_q <= pwdata[smc_pkg::TAP_W-1:0];
      end
    end
  end

  // Register read back.
  always_comb begin
    case (paddr)
      smc_pkg::REG_VOICE_COUNT: prdata = smc_pkg::DATA_W'(vc_q);
      smc_pkg::REG_TAP_SPACING: prdata = smc_pkg::DATA_W'(ts_q);
      default:                  prdata = '0;
    endcase
  end

  // Voice count clamped to 1 .. MAX_VOICES.
  always_comb begin
    if (vc_q == '0) begin
      nv_sel = smc_pkg::VC_W'(1);
    end else if ({1'b0, vc_q} > MaxV) begin
      nv_sel = MaxV[smc_pkg::VC_W-1:0];
    end else begin
      nv_sel = vc_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE) || ts_big;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Tap sequencer.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    wrapped_d   = wrapped_q;
    idx_d       = idx_q;
    taps_left_d = taps_left_q;
    nv_d        = nv_q;
    rd_ok_d     = rd_ok_q;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.wr_en    = 1'b1;
          ctrl.acc_load = 1'b1;
          nv_d          = nv_sel;
          taps_left_d   = nv_sel - smc_pkg::VC_W'(1);
          idx_d         = wrap_back(pos_q, ts_red_q);
          state_d       = (nv_sel == smc_pkg::VC_W'(1)) ? ST_MUL : ST_READ;
        end
      end
      ST_READ: begin
        ctrl.rd_en   = 1'b1;
        ctrl.acc_add = rd_pend_q && rd_ok_q;
        rd_ok_d      = wrapped_q || (idx_q <= pos_q);
        idx_d        = wrap_back(idx_q, ts_red_q);
        taps_left_d  = taps_left_q - smc_pkg::VC_W'(1);
        if (taps_left_q == smc_pkg::VC_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctrl.acc_add = rd_pend_q && rd_ok_q;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          pos_d   = (pos_q == AW'(DELAY_DEPTH - 1)) ? '0 : pos_q + AW'(1);
          wrapped_d = wrapped_q || (pos_q == AW'(DELAY_DEPTH - 1));
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      taps_left_q <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      wrapped_q   <= wrapped_d;
      taps_left_q <= taps_left_d;
      rd_pend_q   <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    nv_q    <= nv_d;
    rd_ok_q <= rd_ok_d;
  end

  assign recip = smc_pkg::recip(nv_q - smc_pkg::VC_W'(1));

  // Channel lanes.
  smc_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .MAX_VOICES  (MAX_VOICES)
  ) u_lane_left (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .wr_addr_i (pos_q),
    .wr_data_i (in_data_i.left_in),
    .rd_addr_i (idx_q),
    .recip_i   (recip),
    .quot_o    (quot_l),
    .neg_o     (neg_l)
  );

  smc_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .MAX_VOICES  (MAX_VOICES)
  ) u_lane_right (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .wr_addr_i (pos_q),
    .wr_data_i (in_data_i.right_in),
    .rd_addr_i (idx_q),
    .recip_i   (recip),
    .quot_o    (quot_r),
    .neg_o     (neg_r)
  );

  // Merge stage: restore the sign and pack both channels.
  assign res_l = neg_l ? (smc_pkg::Q_W'(0) - quot_l) : quot_l;
  assign res_r = neg_r ? (smc_pkg::Q_W'(0) - quot_r) : quot_r;

  always_comb begin
    out_data_d           = out_data_q;
    out_valid_d          = out_valid_q;
    if (out_load) begin
      out_data_d.left_out  = res_l[smc_pkg::SAMPLE_W-1:0];
      out_data_d.right_out = res_r[smc_pkg::SAMPLE_W-1:0];
      out_valid_d          = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks.
  `SMC_ASSERT_NXT(a_accept_starts, in_acc, (state_q == ST_READ) || (state_q == ST_MUL), "accepted transaction did not start the tap sequence")
  `SMC_ASSERT_IMP(a_read_from_seq, rd_pend_q, $past(state_q) == ST_READ, "tap data arrived without a read")
  `SMC_ASSERT_IMP(a_spacing_reduced, state_q != ST_IDLE, !ts_big, "tap spacing not reduced below store depth during a transaction")
  `SMC_ASSERT_IMP(a_taps_left, state_q == ST_READ, taps_left_q != '0, "tap read issued with no taps left")

endmodule

`default_nettype wire
